// ----- rtl/core/imgrot_pkg.sv -----
// Package for the nearest-neighbor image rotation block.
// Holds field widths, register indexes and opcodes; no dependencies.
package imgrot_pkg;

  // Fixed field widths
  localparam int COORD_W = 9;   // pos_x, pos_y
  localparam int DIM_W   = 10;  // frame_width, frame_height
  localparam int COEF_W  = 16;  // cos_angle, sin_angle (Q1.14)
  localparam int CHAN_W  = 8;   // one color channel
  localparam int PIX_W   = 3 * CHAN_W;

  // Datapath widths of the rotation math
  localparam int DELTA_W = COORD_W + 1;       // position minus center, signed
  localparam int PROD_W  = DELTA_W + COEF_W;  // one product
  localparam int SUM_W   = PROD_W + 1;        // sum of two products
  localparam int POS_W   = SUM_W + 1;         // rotated position plus center

  // Stream and config port widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COS    = 2'd2,
    REG_SIN    = 2'd3
  } reg_index_t;

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Reset values of the registers
  localparam logic [DIM_W-1:0]         WIDTH_RST  = 10'd512;
  localparam logic [DIM_W-1:0]         HEIGHT_RST = 10'd512;
  localparam logic signed [COEF_W-1:0] COS_RST    = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SIN_RST    = 16'sd0;

endpackage

// ----- rtl/core/imgrot_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies; contents are undefined until written.
module imgrot_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry; read data holds when not reading
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/image_rotate_nearest.sv -----
// Nearest-neighbor image rotation by inverse mapping over a frame store.
// Depends on imgrot_pkg and imgrot_ram.
// A read word passes through the stage 1, 2, 3 and 4 registers before its result is valid on the output.
// Throughput: one word per cycle, loads and reads in any mix, while results are taken; a
// result held at the output stalls the whole pipeline and the input. Loads and reads share
// the single store port, driven from the third stage.
// Reset clears the pipeline and loads the register defaults; the frame store
// is not cleared and holds undefined data until written.
module image_rotate_nearest
  import imgrot_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x[8:0], pos_y[17:9], in_red[25:18], in_green[33:26], in_blue[41:34], zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic                  s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // inside_res[0]
  output logic                  m_axis_tuser,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [DIM_W-1:0]         frame_width;
  logic [DIM_W-1:0]         frame_height;
  logic signed [COEF_W-1:0] cos_angle;
  logic signed [COEF_W-1:0] sin_angle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      cos_angle    <= COS_RST;
      sin_angle    <= SIN_RST;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_COS:    cos_angle    <= $signed(cfg_data);
        REG_SIN:    sin_angle    <= $signed(cfg_data);
        default:    ;
      endcase
    end
  end

  // Saturate the frame size to the store and take the center
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;

  always_comb begin
    w_eff = (32'(frame_width) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width;
    h_eff = (32'(frame_height) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height;
    cx    = w_eff[DIM_W-1:1];
    cy    = h_eff[DIM_W-1:1];
  end

  // Unpack the input word
  logic               in_op;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [PIX_W-1:0]   in_rgb;

  assign in_op  = s_axis_tuser;
  assign in_x   = s_axis_tdata[8:0];
  assign in_y   = s_axis_tdata[17:9];
  assign in_rgb = {s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[41:34]};

  // Whole pipeline advances unless a result waits at the output
  logic advance;
  logic s4_valid;

  assign advance       = !(s4_valid && !m_axis_tready);
  assign s_axis_tready = advance;

  // Stage 1: offsets from center and the four products
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;

  assign dx = $signed({1'b0, in_x}) - $signed({1'b0, cx});
  assign dy = $signed({1'b0, in_y}) - $signed({1'b0, cy});

  logic                     s1_valid;
  logic                     s1_op;
  logic [COORD_W-1:0]       s1_x;
  logic [COORD_W-1:0]       s1_y;
  logic [PIX_W-1:0]         s1_rgb;
  logic signed [PROD_W-1:0] s1_xc;
  logic signed [PROD_W-1:0] s1_ys;
  logic signed [PROD_W-1:0] s1_yc;
  logic signed [PROD_W-1:0] s1_xs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op  <= in_op;
      s1_x   <= in_x;
      s1_y   <= in_y;
      s1_rgb <= in_rgb;
      s1_xc  <= PROD_W'(dx) * PROD_W'(cos_angle);
      s1_ys  <= PROD_W'(dy) * PROD_W'(sin_angle);
      s1_yc  <= PROD_W'(dy) * PROD_W'(cos_angle);
      s1_xs  <= PROD_W'(dx) * PROD_W'(sin_angle);
    end
  end

  // Stage 2: sum, truncate toward zero, add center back, test bounds
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] bias_x;
  logic signed [SUM_W-1:0] bias_y;
  logic signed [SUM_W-1:0] quo_x;
  logic signed [SUM_W-1:0] quo_y;
  logic signed [POS_W-1:0] src_x;
  logic signed [POS_W-1:0] src_y;
  logic                    src_in;
  logic                    load_in;
  logic [XW-1:0]           sel_x;
  logic [YW-1:0]           sel_y;
  logic                    sel_en;

  always_comb begin
    sum_x   = SUM_W'(s1_xc) - SUM_W'(s1_ys);
    sum_y   = SUM_W'(s1_yc) + SUM_W'(s1_xs);
    bias_x  = sum_x[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0;
    bias_y  = sum_y[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0;
    quo_x   = (sum_x + bias_x) >>> FRAC_BITS;
    quo_y   = (sum_y + bias_y) >>> FRAC_BITS;
    src_x   = POS_W'(quo_x) + $signed(POS_W'(cx));
    src_y   = POS_W'(quo_y) + $signed(POS_W'(cy));
    src_in  = !src_x[POS_W-1] && (src_x < $signed(POS_W'(w_eff))) &&
              !src_y[POS_W-1] && (src_y < $signed(POS_W'(h_eff)));
    load_in = (32'(s1_x) < 32'(MAX_WIDTH)) && (32'(s1_y) < 32'(MAX_HEIGHT));
    if (s1_op == OP_READ) begin
      sel_x  = XW'(src_x);
      sel_y  = YW'(src_y);
      sel_en = src_in;
    end else begin
      sel_x  = XW'(s1_x);
      sel_y  = YW'(s1_y);
      sel_en = load_in;
    end
  end

  logic             s2_valid;
  logic             s2_op;
  logic             s2_en;
  logic [XW-1:0]    s2_x;
  logic [YW-1:0]    s2_y;
  logic [PIX_W-1:0] s2_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op  <= s1_op;
      s2_en  <= sel_en;
      s2_x   <= sel_x;
      s2_y   <= sel_y;
      s2_rgb <= s1_rgb;
    end
  end

  // Stage 3: form the store address from row and column
  logic             s3_valid;
  logic             s3_op;
  logic             s3_en;
  logic [AW-1:0]    s3_addr;
  logic [PIX_W-1:0] s3_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_op   <= s2_op;
      s3_en   <= s2_en;
      s3_addr <= AW'(s2_y) * AW'(MAX_WIDTH) + AW'(s2_x);
      s3_rgb  <= s2_rgb;
    end
  end

  // Stage 4: one store access, a write for a load or a read for a read
  logic             ram_we;
  logic             ram_re;
  logic [PIX_W-1:0] ram_rdata;

  assign ram_we = advance && s3_valid && (s3_op == OP_LOAD) && s3_en;
  assign ram_re = advance && s3_valid && (s3_op == OP_READ) && s3_en;

  imgrot_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (s3_addr),
    .wdata (s3_rgb),
    .rdata (ram_rdata)
  );

  logic s4_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid && (s3_op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_inside <= s3_en;
    end
  end

  // Drive the result word; black when the source point is outside
  logic [PIX_W-1:0] out_rgb;

  assign out_rgb       = s4_inside ? ram_rdata : '0;
  assign m_axis_tvalid = s4_valid;
  assign m_axis_tdata  = {out_rgb[7:0], out_rgb[15:8], out_rgb[23:16]};
  assign m_axis_tuser  = s4_inside;

  // Store port never sees a write and a read together
  assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("frame store written and read in one cycle");

  // A held result blocks new input words
  assert property (@(posedge clk) disable iff (rst)
    (s4_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // Outside results are black
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("outside result is not black");

  // Stalled result keeps its read data
  assert property (@(posedge clk) disable iff (rst)
    (s4_valid && !m_axis_tready) |=> $stable(ram_rdata))
    else $error("store read data changed under stall");

  // Reset empties the pipeline
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

// ----- sim/tb.sv -----
// Testbench for image_rotate_nearest: streams pixel loads and rotated reads and
// checks every result word against a scoreboard that rotates on its own.
// Depends on imgrot_pkg and the RTL of image_rotate_nearest.
module tb;
  import imgrot_pkg::*;

  localparam int STORE_W       = 512;
  localparam int STORE_H       = 512;
  localparam int FRAC          = 14;
  localparam int DEPTH         = STORE_W * STORE_H;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_WORDS   = 105;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              in_frame;
  } pixel_result_t;

  // Scoreboard: own copy of the registers and the frame store, queue of expected pixels
  class rotate_checker;
    logic [DIM_W-1:0]         width  = WIDTH_RST;
    logic [DIM_W-1:0]         height = HEIGHT_RST;
    logic signed [COEF_W-1:0] cos_q  = COS_RST;
    logic signed [COEF_W-1:0] sin_q  = SIN_RST;
    logic [PIX_W-1:0]         frame [DEPTH];
    bit                       written [DEPTH];
    pixel_result_t            expected_pixels [$];
    int                       errors = 0;

    function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WIDTH:  width  = value[DIM_W-1:0];
        REG_HEIGHT: height = value[DIM_W-1:0];
        REG_COS:    cos_q  = value;
        REG_SIN:    sin_q  = value;
        default:    ;
      endcase
    endfunction

    // Saturate the frame size to the store size
    function int eff_width();
      return (width > STORE_W) ? STORE_W : int'(width);
    endfunction

    function int eff_height();
      return (height > STORE_H) ? STORE_H : int'(height);
    endfunction

    // Inverse-map an output position onto the source frame, truncating toward zero
    function void map_source(input int px, input int py,
                             output int sx, output int sy, output bit hit);
      longint w, h, cx, cy, dx, dy, c, s, one;
      w   = eff_width();
      h   = eff_height();
      cx  = w / 2;
      cy  = h / 2;
      c   = cos_q;
      s   = sin_q;
      dx  = px - cx;
      dy  = py - cy;
      one = longint'(1) << FRAC;
      sx  = int'((dx * c - dy * s) / one + cx);
      sy  = int'((dy * c + dx * s) / one + cy);
      hit = (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
    endfunction

    function bit is_written(int x, int y);
      return written[y * STORE_W + x];
    endfunction

    // Apply an accepted word: store a load, or queue the pixel a read must return
    function void note_word(logic op, int px, int py, logic [PIX_W-1:0] rgb);
      int            sx, sy;
      bit            hit;
      pixel_result_t res;
      if (op == OP_LOAD) begin
        frame[py * STORE_W + px]   = rgb;
        written[py * STORE_W + px] = 1'b1;
      end else begin
        map_source(px, py, sx, sy, hit);
        res = '0;
        if (hit) begin
          {res.red, res.green, res.blue} = frame[sy * STORE_W + sx];
          res.in_frame = 1'b1;
        end
        expected_pixels.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one result word against the oldest expected pixel
    function void check_pixel(pixel_result_t got);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, actual %h",
                 $time, got);
      end else begin
        want = expected_pixels.pop_front();
        compare_field("out_red", want.red, got.red);
        compare_field("out_green", want.green, got.green);
        compare_field("out_blue", want.blue, got.blue);
        compare_field("inside_res", 8'(want.in_frame), 8'(got.in_frame));
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  rotate_checker sb = new;
  int            cycles     = 0;
  int            burst_left = 0;
  int            words_sent = 0;
  int            stall_mode = 0;
  int            mode_left  = 0;
  int            stall_left = 0;

  image_rotate_nearest uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check result words, then pick the next stall pattern of the receiver
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_pixel({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                      m_axis_tuser});
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (cycles % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          m_axis_tready <= 1'b0;
          stall_left--;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(3, 12);
        end
      end
    endcase
  end

  // Send one word in bursts with random gaps; note it once accepted
  task automatic send_word(logic op, int x, int y, logic [PIX_W-1:0] rgb);
    int                 gap;
    logic [COORD_W-1:0] xb, yb;
    xb = x[COORD_W-1:0];
    yb = y[COORD_W-1:0];
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, rgb[7:0], rgb[15:8], rgb[23:16], yb, xb};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(op, x, y, rgb);
    burst_left--;
    words_sent++;
  endtask

  // Read a rotated pixel; load its source first if that entry was never written
  task automatic read_pixel(int x, int y);
    int sx, sy;
    bit hit;
    sb.map_source(x, y, sx, sy, hit);
    if (hit && !sb.is_written(sx, sy)) send_word(OP_LOAD, sx, sy, PIX_W'($urandom()));
    send_word(OP_READ, x, y, PIX_W'($urandom()));
  endtask

  // Hold the sender until every expected pixel has come and the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  // Write all four registers while the block is idle
  task automatic configure(int w, int h, int c, int s);
    drain();
    put_reg(REG_WIDTH, CFG_DATA_W'(w));
    put_reg(REG_HEIGHT, CFG_DATA_W'(h));
    put_reg(REG_COS, CFG_DATA_W'(c));
    put_reg(REG_SIN, CFG_DATA_W'(s));
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_coord(int dim);
    if (dim > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, dim - 1);
    return $urandom_range(0, 511);
  endfunction

  // Random mix of loads and reads under one register setting
  task automatic run_phase(int w, int h, int c, int s);
    int start;
    configure(w, h, c, s);
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      if ($urandom_range(0, 99) < 55) begin
        read_pixel(pick_coord(sb.eff_width()), pick_coord(sb.eff_height()));
      end else begin
        send_word(OP_LOAD, pick_coord(sb.eff_width()), pick_coord(sb.eff_height()),
                  PIX_W'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Odd-sized frame, identity: corners, center, loads and reads off the frame
    configure(5, 3, 16384, 0);
    send_word(OP_LOAD, 0, 0, 24'h000000);
    send_word(OP_LOAD, 4, 2, 24'hFFFFFF);
    send_word(OP_LOAD, 511, 511, 24'hA55AC3);
    send_word(OP_LOAD, 2, 1, 24'h123456);
    read_pixel(0, 0);
    read_pixel(4, 2);
    read_pixel(2, 1);
    read_pixel(5, 0);
    read_pixel(511, 511);

    // Half turn swaps the corners
    configure(5, 3, -16384, 0);
    read_pixel(4, 2);
    read_pixel(0, 0);

    // Zero width: nothing is inside
    configure(0, 3, 16384, 0);
    read_pixel(0, 0);
    read_pixel(2, 1);

    // Oversized frame saturates to the store
    configure(1023, 1023, 16384, 0);
    read_pixel(511, 511);
    read_pixel(0, 0);

    // Coefficients at the ends of their range
    configure(512, 512, -32768, 32767);
    read_pixel(256, 256);
    read_pixel(0, 511);
    read_pixel(511, 0);

    // Random part over several settings
    run_phase(512, 512, 16384, 0);
    run_phase(512, 512, 0, 16384);
    run_phase(64, 48, 11585, 11585);
    run_phase(33, 17, -16384, 0);
    run_phase(1, 1, 14189, 8192);
    run_phase(2, 511, 0, -16384);
    run_phase(1023, 700, $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
    run_phase(0, 9, $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase(300, 200, -32768, 32767);
    run_phase($urandom_range(1, 600), $urandom_range(1, 600),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase($urandom_range(1, 40), $urandom_range(1, 40),
              $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
